### hdl/connection_lru_tracker_unit_assert.svh
// Assertion macros for the connection LRU tracker.
// Expects clk and arst_n to be visible where the macros are used.
`ifndef CONNECTION_LRU_TRACKER_UNIT_ASSERT_SVH
`define CONNECTION_LRU_TRACKER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CLT_ASSERT_SAME(label, ante, cons) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("connection tracker check failed");

// Consequent must hold in the cycle after the antecedent.
`define CLT_ASSERT_NEXT(label, ante, cons) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("connection tracker check failed");

`endif

### hdl/clt_pkg.sv
// Shared constants and types for the connection LRU tracker.
// No dependencies; every file but clt_ram and the assert header imports this package.
package clt_pkg;

	localparam int unsigned SLOTS = 256;
	localparam int unsigned SLOT_W = $clog2(SLOTS);
	localparam int unsigned PTR_W = SLOT_W + 1;
	localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(SLOTS);

	localparam int unsigned REQ_W = 2;
	localparam int unsigned SLOT_FIELD_W = 8;
	localparam int unsigned TIME_W = 32;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned COUNT_W = 9;
	localparam int unsigned TOTAL_W = 32;
	localparam int unsigned MAX_CONN_W = 8;

	localparam int unsigned APB_ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;
	localparam int unsigned REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_MAX_CONN = 1'd0;
	localparam logic [MAX_CONN_W-1:0] MAX_CONN_RESET = 8'd255;

	localparam logic [REQ_W-1:0] REQ_OPEN = 2'd0;
	localparam logic [REQ_W-1:0] REQ_ACTIVE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CLOSE = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_ALREADY_OPEN = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_OPEN = 2'd2;

	typedef struct packed {
		logic              we;
		logic [SLOT_W-1:0] waddr;
		logic [PTR_W-1:0]  wdata;
		logic [SLOT_W-1:0] raddr;
	} link_ram_req_t;

	typedef struct packed {
		logic              we;
		logic [SLOT_W-1:0] waddr;
		logic [TIME_W-1:0] wdata;
		logic [SLOT_W-1:0] raddr;
	} time_ram_req_t;

	typedef struct packed {
		logic              we;
		logic [SLOT_W-1:0] waddr;
		logic              wdata;
		logic [SLOT_W-1:0] raddr;
	} mark_ram_req_t;

endpackage

### hdl/clt_ifs.sv
// Request and result channel interfaces of the connection LRU tracker.
// Depends on clt_pkg for field widths.
interface clt_req_if;
	import clt_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [REQ_W-1:0]        req_type;
	logic [SLOT_FIELD_W-1:0] slot;
	logic [TIME_W-1:0]       now_time;

	modport source(output valid, req_type, slot, now_time, input ready);
	modport sink(input valid, req_type, slot, now_time, output ready);
endinterface

interface clt_res_if;
	import clt_pkg::*;
	logic                    valid;
	logic                    ready;
	logic                    close_flag;
	logic [STATUS_W-1:0]     status;
	logic [SLOT_FIELD_W-1:0] head_slot;
	logic [SLOT_FIELD_W-1:0] tail_slot;
	logic                    list_empty;
	logic [TIME_W-1:0]       oldest_time;
	logic [COUNT_W-1:0]      open_count;
	logic [TOTAL_W-1:0]      opened_total;
	logic [TOTAL_W-1:0]      closed_total;

	modport source(output valid, close_flag, status, head_slot, tail_slot, list_empty,
		oldest_time, open_count, opened_total, closed_total, input ready);
	modport sink(input valid, close_flag, status, head_slot, tail_slot, list_empty,
		oldest_time, open_count, opened_total, closed_total, output ready);
endinterface

### hdl/clt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module clt_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

### hdl/clt_cfg.sv
// APB-style configuration register block: holds max_connections.
// Depends on clt_pkg for address and data widths.
module clt_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [clt_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [clt_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [clt_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready,
	output logic [clt_pkg::MAX_CONN_W-1:0]   max_conn
);
	import clt_pkg::*;

	logic [MAX_CONN_W-1:0] max_conn_q;
	logic [REG_IDX_W-1:0]  reg_idx;
	logic                  wr_en;

	// word index: drop the byte offset
	assign reg_idx = paddr[APB_ADDR_W-1:2];
	assign wr_en = psel && penable && pwrite && (reg_idx == REG_MAX_CONN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_conn_q <= MAX_CONN_RESET;
		end else if (wr_en) begin
			max_conn_q <= pwdata[MAX_CONN_W-1:0];
		end
	end

	assign prdata = (reg_idx == REG_MAX_CONN) ? APB_DATA_W'(max_conn_q) : '0;
	assign pready = 1'b1;
	assign max_conn = max_conn_q;
endmodule

### hdl/clt_ctrl.sv
// Request sequencer: valid bits, list pointers, counters and result register.
// Drives the link, time and mark RAMs; depends on clt_pkg and clt_ifs.
module clt_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [clt_pkg::MAX_CONN_W-1:0]  max_conn,
	clt_req_if.sink                         req,
	clt_res_if.source                       res,
	output clt_pkg::link_ram_req_t          prev_ram,
	output clt_pkg::link_ram_req_t          next_ram,
	output clt_pkg::time_ram_req_t          time_ram,
	output clt_pkg::mark_ram_req_t          mark_ram,
	input  logic [clt_pkg::PTR_W-1:0]       prev_rdata,
	input  logic [clt_pkg::PTR_W-1:0]       next_rdata,
	input  logic [clt_pkg::TIME_W-1:0]      time_rdata,
	input  logic                            mark_rdata
);
	import clt_pkg::*;

	localparam int unsigned CMP_W = (PTR_W > SLOT_FIELD_W) ? PTR_W : SLOT_FIELD_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LINK1,
		S_LINK2,
		S_LINK3,
		S_READ,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_OPEN,
		OP_ACTIVE,
		OP_CLOSE
	} op_t;

	state_t                  state_q;
	op_t                     op_q;
	op_t                     op_d;
	logic [STATUS_W-1:0]     status_q;
	logic [STATUS_W-1:0]     status_d;
	logic [SLOT_W-1:0]       slot_q;
	logic                    in_range_q;
	logic [TIME_W-1:0]       time_q;
	logic [PTR_W-1:0]        prev_q;
	logic [PTR_W-1:0]        next_q;
	logic [PTR_W-1:0]        old_head_q;
	logic [PTR_W-1:0]        head_q;
	logic [PTR_W-1:0]        tail_q;
	logic [SLOTS-1:0]        valid_q;
	logic [PTR_W-1:0]        count_q;
	logic [TOTAL_W-1:0]      opened_q;
	logic [TOTAL_W-1:0]      closed_q;

	logic                    out_valid_q;
	logic                    close_flag_q;
	logic [STATUS_W-1:0]     out_status_q;
	logic [SLOT_FIELD_W-1:0] head_slot_q;
	logic [SLOT_FIELD_W-1:0] tail_slot_q;
	logic                    list_empty_q;
	logic [TIME_W-1:0]       oldest_time_q;
	logic [COUNT_W-1:0]      open_count_q;
	logic [TOTAL_W-1:0]      opened_total_q;
	logic [TOTAL_W-1:0]      closed_total_q;

	logic                    accept;
	logic                    in_range;
	logic [SLOT_W-1:0]       in_idx;
	logic                    in_open;
	logic                    over_limit;
	logic                    fin_open;
	logic [PTR_W-1:0]        slot_ptr;

	function automatic logic is_null(logic [PTR_W-1:0] p);
		return p >= NULL_PTR;
	endfunction

	assign accept = req.valid && req.ready;
	assign in_range = CMP_W'(req.slot) < CMP_W'(SLOTS);
	assign in_idx = SLOT_W'(req.slot);
	assign in_open = in_range && valid_q[in_idx];
	// new count exceeds limit + 1 exactly when the old count exceeds the limit
	assign over_limit = CMP_W'(count_q) > CMP_W'(max_conn);
	assign fin_open = in_range_q && valid_q[slot_q];
	assign slot_ptr = PTR_W'(slot_q);

	// classify the incoming request
	always_comb begin
		op_d = OP_NONE;
		status_d = ST_OK;
		case (req.req_type)
			REQ_OPEN: begin
				if (!in_range) begin
					status_d = ST_NOT_OPEN;
				end else if (in_open) begin
					status_d = ST_ALREADY_OPEN;
				end else begin
					op_d = OP_OPEN;
				end
			end
			REQ_ACTIVE: begin
				if (!in_open) begin
					status_d = ST_NOT_OPEN;
				end else begin
					op_d = OP_ACTIVE;
				end
			end
			REQ_CLOSE: begin
				if (!in_open) begin
					status_d = ST_NOT_OPEN;
				end else begin
					op_d = OP_CLOSE;
				end
			end
			default: begin
				op_d = OP_NONE;
			end
		endcase
	end

	// memory accesses; links of the slot are read as the request is taken
	always_comb begin
		prev_ram = '0;
		next_ram = '0;
		time_ram = '0;
		mark_ram = '0;
		prev_ram.raddr = (state_q == S_IDLE) ? in_idx : slot_q;
		next_ram.raddr = (state_q == S_IDLE) ? in_idx : slot_q;
		time_ram.raddr = tail_q[SLOT_W-1:0];
		mark_ram.raddr = slot_q;
		unique case (state_q)
			S_LINK1: begin
				case (op_q)
					OP_OPEN: begin
						prev_ram.we = 1'b1;
						prev_ram.waddr = slot_q;
						prev_ram.wdata = NULL_PTR;
						next_ram.we = 1'b1;
						next_ram.waddr = slot_q;
						next_ram.wdata = head_q;
						time_ram.we = 1'b1;
						time_ram.waddr = slot_q;
						time_ram.wdata = time_q;
						mark_ram.we = 1'b1;
						mark_ram.waddr = slot_q;
						mark_ram.wdata = over_limit;
					end
					OP_ACTIVE: begin
						time_ram.we = 1'b1;
						time_ram.waddr = slot_q;
						time_ram.wdata = time_q;
						// not at the head: bypass it and detach its back link
						if (!is_null(prev_rdata)) begin
							next_ram.we = 1'b1;
							next_ram.waddr = prev_rdata[SLOT_W-1:0];
							next_ram.wdata = next_rdata;
							prev_ram.we = 1'b1;
							prev_ram.waddr = slot_q;
							prev_ram.wdata = NULL_PTR;
						end
					end
					OP_CLOSE: begin
						next_ram.we = !is_null(prev_rdata);
						next_ram.waddr = prev_rdata[SLOT_W-1:0];
						next_ram.wdata = next_rdata;
						prev_ram.we = !is_null(next_rdata);
						prev_ram.waddr = next_rdata[SLOT_W-1:0];
						prev_ram.wdata = prev_rdata;
					end
					default: begin
						prev_ram.we = 1'b0;
					end
				endcase
			end
			S_LINK2: begin
				if (op_q == OP_OPEN) begin
					prev_ram.we = !is_null(old_head_q);
					prev_ram.waddr = old_head_q[SLOT_W-1:0];
					prev_ram.wdata = slot_ptr;
				end else begin
					next_ram.we = 1'b1;
					next_ram.waddr = slot_q;
					next_ram.wdata = old_head_q;
					prev_ram.we = !is_null(next_q);
					prev_ram.waddr = next_q[SLOT_W-1:0];
					prev_ram.wdata = prev_q;
				end
			end
			S_LINK3: begin
				prev_ram.we = 1'b1;
				prev_ram.waddr = old_head_q[SLOT_W-1:0];
				prev_ram.wdata = slot_ptr;
			end
			S_IDLE, S_READ, S_DONE: begin
				prev_ram.we = 1'b0;
			end
			default: begin
				prev_ram.we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= OP_NONE;
			status_q <= ST_OK;
			slot_q <= '0;
			in_range_q <= 1'b0;
			time_q <= '0;
			prev_q <= NULL_PTR;
			next_q <= NULL_PTR;
			old_head_q <= NULL_PTR;
			head_q <= NULL_PTR;
			tail_q <= NULL_PTR;
			valid_q <= '0;
			count_q <= '0;
			opened_q <= '0;
			closed_q <= '0;
			out_valid_q <= 1'b0;
			close_flag_q <= 1'b0;
			out_status_q <= ST_OK;
			head_slot_q <= '0;
			tail_slot_q <= '0;
			list_empty_q <= 1'b1;
			oldest_time_q <= '0;
			open_count_q <= '0;
			opened_total_q <= '0;
			closed_total_q <= '0;
		end else begin
			// in the final step the result load below takes over
			if (res.valid && res.ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q <= op_d;
						status_q <= status_d;
						slot_q <= in_idx;
						in_range_q <= in_range;
						time_q <= req.now_time;
						state_q <= (op_d == OP_NONE) ? S_READ : S_LINK1;
					end
				end
				S_LINK1: begin
					prev_q <= prev_rdata;
					next_q <= next_rdata;
					old_head_q <= head_q;
					case (op_q)
						OP_OPEN: begin
							valid_q[slot_q] <= 1'b1;
							head_q <= slot_ptr;
							if (is_null(tail_q)) begin
								tail_q <= slot_ptr;
							end
							count_q <= count_q + 1'b1;
							opened_q <= opened_q + 1'b1;
							state_q <= S_LINK2;
						end
						OP_ACTIVE: begin
							if (!is_null(prev_rdata)) begin
								if (is_null(next_rdata)) begin
									tail_q <= prev_rdata;
								end
								state_q <= S_LINK2;
							end else begin
								state_q <= S_READ;
							end
						end
						OP_CLOSE: begin
							if (is_null(prev_rdata)) begin
								head_q <= next_rdata;
							end
							if (is_null(next_rdata)) begin
								tail_q <= prev_rdata;
							end
							valid_q[slot_q] <= 1'b0;
							if (count_q != '0) begin
								count_q <= count_q - 1'b1;
							end
							closed_q <= closed_q + 1'b1;
							state_q <= S_READ;
						end
						default: begin
							state_q <= S_READ;
						end
					endcase
				end
				S_LINK2: begin
					state_q <= (op_q == OP_OPEN) ? S_READ : S_LINK3;
				end
				S_LINK3: begin
					head_q <= slot_ptr;
					state_q <= S_READ;
				end
				S_READ: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					// hold here until the result register is free
					if (!out_valid_q || res.ready) begin
						out_valid_q <= 1'b1;
						close_flag_q <= fin_open && mark_rdata;
						out_status_q <= status_q;
						head_slot_q <= is_null(head_q) ? '0 :
							SLOT_FIELD_W'(head_q[SLOT_W-1:0]);
						tail_slot_q <= is_null(tail_q) ? '0 :
							SLOT_FIELD_W'(tail_q[SLOT_W-1:0]);
						list_empty_q <= is_null(head_q);
						oldest_time_q <= is_null(tail_q) ? '0 : time_rdata;
						open_count_q <= COUNT_W'(count_q);
						opened_total_q <= opened_q;
						closed_total_q <= closed_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req.ready = (state_q == S_IDLE);
	assign res.valid = out_valid_q;
	assign res.close_flag = close_flag_q;
	assign res.status = out_status_q;
	assign res.head_slot = head_slot_q;
	assign res.tail_slot = tail_slot_q;
	assign res.list_empty = list_empty_q;
	assign res.oldest_time = oldest_time_q;
	assign res.open_count = open_count_q;
	assign res.opened_total = opened_total_q;
	assign res.closed_total = closed_total_q;
endmodule

### hdl/connection_lru_tracker_unit.sv
// Connection LRU tracker: top level with config block, sequencer and RAMs.
// Depends on clt_pkg, clt_ifs, clt_ram, clt_cfg, clt_ctrl and the assert header.
//
// Usage:
//   req (valid/ready): one request per handshake: req_type (open, active, close),
//     slot and now_time. res (valid/ready): one result per request, in order.
//   APB port: max_connections at byte address 0; pready is always high.
// Sequencing:
//   A request is taken only while the sequencer is idle; after acceptance it
//   steps through: ignored or refused request S_READ, S_DONE; close or head touch
//   S_LINK1, S_READ, S_DONE; open S_LINK1, S_LINK2, S_READ, S_DONE; move to front
//   S_LINK1, S_LINK2, S_LINK3, S_READ, S_DONE. The prev-link RAM write port sets
//   this: a move to front writes it up to three times, each in its own state.
// Reset:
//   arst_n clears valid bits, pointers, counters and the result register;
//   max_connections returns to 255. No RAM clearing pass is needed.
// Stall:
//   A finished result waits in the output register; the sequencer holds in its
//   final step and takes no new request until that register is free.
`include "connection_lru_tracker_unit_assert.svh"

module connection_lru_tracker_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [clt_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [clt_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [clt_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready,
	clt_req_if.sink                          req,
	clt_res_if.source                        res
);
	import clt_pkg::*;

	logic [MAX_CONN_W-1:0] max_conn;
	link_ram_req_t         prev_ram;
	link_ram_req_t         next_ram;
	time_ram_req_t         time_ram;
	mark_ram_req_t         mark_ram;
	logic [PTR_W-1:0]      prev_rdata;
	logic [PTR_W-1:0]      next_rdata;
	logic [TIME_W-1:0]     time_rdata;
	logic                  mark_rdata;

	clt_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.max_conn (max_conn)
	);

	clt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.max_conn   (max_conn),
		.req        (req),
		.res        (res),
		.prev_ram   (prev_ram),
		.next_ram   (next_ram),
		.time_ram   (time_ram),
		.mark_ram   (mark_ram),
		.prev_rdata (prev_rdata),
		.next_rdata (next_rdata),
		.time_rdata (time_rdata),
		.mark_rdata (mark_rdata)
	);

	clt_ram #(.WIDTH(PTR_W), .DEPTH(SLOTS)) u_prev_ram (
		.clk   (clk),
		.we    (prev_ram.we),
		.waddr (prev_ram.waddr),
		.wdata (prev_ram.wdata),
		.raddr (prev_ram.raddr),
		.rdata (prev_rdata)
	);

	clt_ram #(.WIDTH(PTR_W), .DEPTH(SLOTS)) u_next_ram (
		.clk   (clk),
		.we    (next_ram.we),
		.waddr (next_ram.waddr),
		.wdata (next_ram.wdata),
		.raddr (next_ram.raddr),
		.rdata (next_rdata)
	);

	clt_ram #(.WIDTH(TIME_W), .DEPTH(SLOTS)) u_time_ram (
		.clk   (clk),
		.we    (time_ram.we),
		.waddr (time_ram.waddr),
		.wdata (time_ram.wdata),
		.raddr (time_ram.raddr),
		.rdata (time_rdata)
	);

	clt_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_mark_ram (
		.clk   (clk),
		.we    (mark_ram.we),
		.waddr (mark_ram.waddr),
		.wdata (mark_ram.wdata),
		.raddr (mark_ram.raddr),
		.rdata (mark_rdata)
	);

	// the sequencer is busy in the cycle after taking a request
	`CLT_ASSERT_NEXT(a_busy_after_req, req.valid && req.ready, !req.ready)
	`CLT_ASSERT_SAME(a_empty_count, res.valid, res.list_empty == (res.open_count == '0))
	`CLT_ASSERT_SAME(a_empty_fields, res.valid && res.list_empty, res.head_slot == '0 && res.tail_slot == '0 && res.oldest_time == '0)
	`CLT_ASSERT_SAME(a_not_open_mark, res.valid && res.status == ST_NOT_OPEN, !res.close_flag)
endmodule

### verif/clt_tracker_sb_pkg.sv
`timescale 1ns / 100ps
// Recency-list predictor and result checker for the connection LRU tracker bench.
// Depends on clt_pkg for widths, the null pointer marker and the request/status codes.
package clt_tracker_sb_pkg;
	import clt_pkg::*;

	// request code the block takes but ignores
	localparam logic [REQ_W-1:0] REQ_IGNORED = 2'd3;

	typedef struct packed {
		logic                    close_flag;
		logic [STATUS_W-1:0]     status;
		logic [SLOT_FIELD_W-1:0] head_slot;
		logic [SLOT_FIELD_W-1:0] tail_slot;
		logic                    list_empty;
		logic [TIME_W-1:0]       oldest_time;
		logic [COUNT_W-1:0]      open_count;
		logic [TOTAL_W-1:0]      opened_total;
		logic [TOTAL_W-1:0]      closed_total;
	} conn_snapshot_t;

	class conn_recency_sb;
		logic [MAX_CONN_W-1:0] max_conn;
		bit                    live[SLOTS];
		logic [PTR_W-1:0]      prev_of[SLOTS];
		logic [PTR_W-1:0]      next_of[SLOTS];
		logic [TIME_W-1:0]     stamp[SLOTS];
		bit                    marked[SLOTS];
		logic [PTR_W-1:0]      head;
		logic [PTR_W-1:0]      tail;
		logic [COUNT_W-1:0]    open_now;
		logic [TOTAL_W-1:0]    opens;
		logic [TOTAL_W-1:0]    closes;
		conn_snapshot_t        due[$];
		int unsigned           errors;
		int unsigned           checked;
		int unsigned           marks_seen;
		int unsigned           peak_open;

		function new();
			max_conn = MAX_CONN_RESET;
			foreach (live[i]) begin
				live[i] = 1'b0;
				prev_of[i] = '0;
				next_of[i] = '0;
				stamp[i] = '0;
				marked[i] = 1'b0;
			end
			head = NULL_PTR;
			tail = NULL_PTR;
			open_now = '0;
			opens = '0;
			closes = '0;
			errors = 0;
			checked = 0;
			marks_seen = 0;
			peak_open = 0;
		endfunction

		function void unlink(logic [SLOT_W-1:0] s);
			logic [PTR_W-1:0] p;
			logic [PTR_W-1:0] n;
			p = prev_of[s];
			n = next_of[s];
			if (p != NULL_PTR) next_of[p[SLOT_W-1:0]] = n;
			else head = n;
			if (n != NULL_PTR) prev_of[n[SLOT_W-1:0]] = p;
			else tail = p;
		endfunction

		function void link_front(logic [SLOT_W-1:0] s);
			prev_of[s] = NULL_PTR;
			next_of[s] = head;
			if (head != NULL_PTR) prev_of[head[SLOT_W-1:0]] = {1'b0, s};
			head = {1'b0, s};
			if (tail == NULL_PTR) tail = {1'b0, s};
		endfunction

		// k-th open slot counting from the most recent one
		function logic [SLOT_W-1:0] nth_open(int unsigned k);
			logic [PTR_W-1:0] p;
			p = head;
			repeat (k)
				if (next_of[p[SLOT_W-1:0]] != NULL_PTR) p = next_of[p[SLOT_W-1:0]];
			return p[SLOT_W-1:0];
		endfunction

		function void apply_request(logic [REQ_W-1:0] kind, logic [SLOT_FIELD_W-1:0] s,
				logic [TIME_W-1:0] t);
			conn_snapshot_t r;
			bit was_open;
			r = '0;
			r.status = ST_OK;
			was_open = live[s];
			case (kind)
				REQ_OPEN: begin
					if (was_open) begin
						r.status = ST_ALREADY_OPEN;
					end else begin
						live[s] = 1'b1;
						stamp[s] = t;
						link_front(s);
						open_now++;
						opens++;
						marked[s] = int'(open_now) > int'(max_conn) + 1;
					end
				end
				REQ_ACTIVE: begin
					if (!was_open) begin
						r.status = ST_NOT_OPEN;
					end else begin
						stamp[s] = t;
						// the head only gets a new stamp
						if (prev_of[s] != NULL_PTR) begin
							unlink(s);
							link_front(s);
						end
					end
				end
				REQ_CLOSE: begin
					if (!was_open) begin
						r.status = ST_NOT_OPEN;
					end else begin
						unlink(s);
						live[s] = 1'b0;
						if (open_now != 0) open_now--;
						closes++;
					end
				end
				default: ;
			endcase
			r.close_flag = live[s] ? marked[s] : 1'b0;
			r.list_empty = head == NULL_PTR;
			r.head_slot = r.list_empty ? '0 : head[SLOT_W-1:0];
			r.tail_slot = (tail == NULL_PTR) ? '0 : tail[SLOT_W-1:0];
			r.oldest_time = (tail == NULL_PTR) ? '0 : stamp[tail[SLOT_W-1:0]];
			r.open_count = open_now;
			r.opened_total = opens;
			r.closed_total = closes;
			if (r.close_flag) marks_seen++;
			if (open_now > peak_open) peak_open = int'(open_now);
			due.push_back(r);
		endfunction

		function string show(conn_snapshot_t r);
			return $sformatf("mark=%0d st=%0d head=%0d tail=%0d empty=%0d oldest=%h open=%0d %0d/%0d",
				r.close_flag, r.status, r.head_slot, r.tail_slot, r.list_empty,
				r.oldest_time, r.open_count, r.opened_total, r.closed_total);
		endfunction

		function void flag(string what);
			errors++;
			if (errors <= 10) $display("[%0t] MISMATCH %s", $time, what);
		endfunction

		function void check_result(conn_snapshot_t got);
			conn_snapshot_t want;
			string bad;
			checked++;
			if (due.size() == 0) begin
				flag({"result with no request outstanding: ", show(got)});
				return;
			end
			want = due.pop_front();
			bad = "";
			if (got.close_flag !== want.close_flag) bad = {bad, " close_flag"};
			if (got.status !== want.status) bad = {bad, " status"};
			if (got.head_slot !== want.head_slot) bad = {bad, " head_slot"};
			if (got.tail_slot !== want.tail_slot) bad = {bad, " tail_slot"};
			if (got.list_empty !== want.list_empty) bad = {bad, " list_empty"};
			if (got.oldest_time !== want.oldest_time) bad = {bad, " oldest_time"};
			if (got.open_count !== want.open_count) bad = {bad, " open_count"};
			if (got.opened_total !== want.opened_total) bad = {bad, " opened_total"};
			if (got.closed_total !== want.closed_total) bad = {bad, " closed_total"};
			if (bad != "")
				flag($sformatf("result %0d,%s: expected %s, got %s", checked, bad,
					show(want), show(got)));
		endfunction
	endclass

endpackage

### verif/tb_top.sv
`timescale 1ns / 100ps
// Bench top for connection_lru_tracker_unit: clock, reset, APB writes, request driver
// and result sink around the recency-list scoreboard.
// Depends on clt_pkg, clt_ifs, clt_tracker_sb_pkg and the block's RTL.
module tb_top;
	import clt_pkg::*;
	import clt_tracker_sb_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned SETTLE_CYCLES = 12;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	clt_req_if req_ch();
	clt_res_if res_ch();

	conn_recency_sb sb;
	bit             no_gaps;
	bit             sink_on;
	int unsigned    cycles = 0;
	int unsigned    requests_sent = 0;

	connection_lru_tracker_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.req(req_ch),
		.res(res_ch)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timed out after %0d cycles, %0d results outstanding", cycles,
				sb.due.size());
			$display("connection_lru_tracker_unit verification failed");
			$finish;
		end
	end

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
			input logic [APB_DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_ADDR_W'(int'(idx) * 4);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (idx == REG_MAX_CONN) sb.max_conn = value[MAX_CONN_W-1:0];
	endtask

	// drop valid and hold until every result is back and the block has settled
	task automatic drain();
		req_ch.valid <= 1'b0;
		while (sb.due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send(input logic [REQ_W-1:0] kind, input logic [SLOT_FIELD_W-1:0] s,
			input logic [TIME_W-1:0] t);
		int unsigned gap;
		gap = no_gaps ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.slot <= s;
		req_ch.now_time <= t;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		sb.apply_request(kind, s, t);
		requests_sent++;
	endtask

	// mostly well-formed: opens aim at closed slots, the rest at open ones
	task automatic random_phase(input int unsigned count, input int unsigned span);
		logic [REQ_W-1:0]        kind;
		logic [SLOT_FIELD_W-1:0] s;
		int unsigned             roll;
		int unsigned             tries;
		for (int unsigned i = 0; i < count; i++) begin
			no_gaps = ((i / 40) % 5) == 2;
			if (i == count / 2) drain();
			roll = $urandom_range(0, 99);
			if (roll < 4) kind = REQ_IGNORED;
			else if (roll < 40) kind = REQ_OPEN;
			else if (roll < 72) kind = REQ_ACTIVE;
			else kind = REQ_CLOSE;
			s = SLOT_FIELD_W'($urandom_range(0, span - 1));
			if ($urandom_range(0, 99) < 85) begin
				if (kind == REQ_OPEN) begin
					tries = 0;
					while (sb.live[s] && tries < 8) begin
						s = SLOT_FIELD_W'($urandom_range(0, span - 1));
						tries++;
					end
				end else if (kind != REQ_IGNORED && sb.open_now != 0) begin
					s = sb.nth_open($urandom_range(0, int'(sb.open_now) - 1));
				end
			end
			send(kind, s, $urandom());
		end
		no_gaps = 1'b0;
	endtask

	// open every slot once, in shuffled order
	task automatic fill_table();
		logic [SLOT_W-1:0] order[SLOTS];
		logic [SLOT_W-1:0] swap;
		int unsigned       j;
		foreach (order[i]) order[i] = SLOT_W'(i);
		for (int i = SLOTS - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			swap = order[i];
			order[i] = order[j];
			order[j] = swap;
		end
		foreach (order[i]) send(REQ_OPEN, order[i], $urandom());
	endtask

	initial begin
		int unsigned    stall;
		conn_snapshot_t got;
		res_ch.ready = 1'b0;
		wait (sink_on);
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, 9);
			if (stall != 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			@(posedge clk);
			while (!res_ch.valid) @(posedge clk);
			got = {res_ch.close_flag, res_ch.status, res_ch.head_slot, res_ch.tail_slot,
				res_ch.list_empty, res_ch.oldest_time, res_ch.open_count,
				res_ch.opened_total, res_ch.closed_total};
			sb.check_result(got);
		end
	end

	initial begin
		sb = new();
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_OPEN;
		req_ch.slot = '0;
		req_ch.now_time = '0;
		no_gaps = 1'b0;
		sink_on = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		sink_on = 1'b1;

		write_reg(REG_MAX_CONN, APB_DATA_W'(MAX_CONN_RESET));
		// requests on an empty table
		send(REQ_CLOSE, 8'd5, 32'h0000_0010);
		send(REQ_ACTIVE, 8'd5, 32'h0000_0011);
		send(REQ_IGNORED, 8'd0, 32'h0000_0012);
		// build a short list, extremes of slot and time
		send(REQ_OPEN, 8'd0, 32'h0000_0000);
		send(REQ_OPEN, 8'd255, 32'hFFFF_FFFF);
		send(REQ_OPEN, 8'd0, 32'h0000_0020);
		send(REQ_OPEN, 8'd128, 32'h0000_1234);
		send(REQ_ACTIVE, 8'd128, 32'h8000_0000);
		send(REQ_ACTIVE, 8'd0, 32'h7FFF_FFFF);
		send(REQ_ACTIVE, 8'd255, 32'hA5A5_5A5A);
		send(REQ_CLOSE, 8'd128, 32'h0000_0030);
		send(REQ_IGNORED, 8'd0, 32'h0000_0031);
		send(REQ_CLOSE, 8'd255, 32'h0000_0032);
		send(REQ_CLOSE, 8'd255, 32'h0000_0033);
		send(REQ_CLOSE, 8'd0, 32'h0000_0034);
		send(REQ_OPEN, 8'hAA, 32'h5555_AAAA);
		send(REQ_OPEN, 8'h55, 32'hAAAA_5555);
		send(REQ_CLOSE, 8'h55, 32'h0000_0040);
		send(REQ_CLOSE, 8'hAA, 32'h0000_0041);
		drain();

		// tightest limit: every open beyond the first open connection is over the limit
		write_reg(REG_MAX_CONN, '0);
		send(REQ_OPEN, 8'd1, 32'h0000_0100);
		send(REQ_OPEN, 8'd2, 32'h0000_0101);
		send(REQ_OPEN, 8'd2, 32'h0000_0102);
		send(REQ_IGNORED, 8'd2, 32'h0000_0103);
		random_phase(380, 16);
		drain();

		// full table, the open that fills it goes over the limit
		write_reg(REG_MAX_CONN, APB_DATA_W'(254));
		fill_table();
		random_phase(260, SLOTS);
		drain();

		write_reg(REG_MAX_CONN, APB_DATA_W'($urandom_range(1, 20)));
		random_phase(380, 32);
		drain();

		write_reg(REG_MAX_CONN, APB_DATA_W'(MAX_CONN_RESET));
		random_phase(200, SLOTS);
		drain();

		$display("Ran %0d requests over five limit settings: %0d results checked,",
			requests_sent, sb.checked);
		$display("%0d over-limit marks expected, peak of %0d open connections.",
			sb.marks_seen, sb.peak_open);
		if (sb.errors == 0 && sb.due.size() == 0) begin
			$display("connection_lru_tracker_unit verification clean");
		end else begin
			$display("%0d mismatches, %0d results missing", sb.errors, sb.due.size());
			$display("connection_lru_tracker_unit verification failed");
		end
		$finish;
	end

endmodule
